// ----- sv/ctf_pkg.sv -----
// shared constants, types and the arctangent table of the complementary tilt filter
package ctf_pkg;

  localparam int CTF_STEPS     = 16;
  localparam int CTF_F         = 16;
  localparam int CTF_ITER_W    = $clog2(CTF_STEPS);
  localparam int CTF_ATAN_W    = 30;
  localparam int CTF_TAB_FRAC  = 24;
  localparam int CTF_CW        = 35;
  localparam int CTF_ANG_W     = CTF_F + 10;
  localparam int CTF_PROD_W    = 41;
  localparam int CTF_SCL_W     = CTF_PROD_W + CTF_F + 1;
  localparam int CTF_SUM_W     = CTF_PROD_W + ((CTF_F > 16) ? (CTF_F - 16) : 0) + 2;
  localparam int CTF_MA_W      = CTF_SUM_W;
  localparam int CTF_MB_W      = 13;
  localparam int CTF_MP_W      = CTF_MA_W + CTF_MB_W;
  localparam int CTF_ACC_W     = CTF_MA_W + 26;
  localparam int CTF_GAIN_W    = 24;
  localparam int CTF_LIMIT     = 180 * (2 ** CTF_F);

  localparam logic [CTF_GAIN_W-1:0] CTF_LG_RESET = 24'd8388557;
  localparam logic [CTF_GAIN_W-1:0] CTF_HG_RESET = 24'd52;
  localparam logic [CTF_GAIN_W-1:0] CTF_BG_RESET = 24'd2432696;

  localparam logic [1:0] CTF_REG_LOWPASS  = 2'd0;
  localparam logic [1:0] CTF_REG_HIGHPASS = 2'd1;
  localparam logic [1:0] CTF_REG_BLEND    = 2'd2;

  typedef enum logic [3:0] {
    CTF_S_IDLE,
    CTF_S_CORDIC,
    CTF_S_LP0,
    CTF_S_LP1,
    CTF_S_LP2,
    CTF_S_LP3,
    CTF_S_LPF,
    CTF_S_SUM,
    CTF_S_H0,
    CTF_S_H1,
    CTF_S_HPF,
    CTF_S_B1,
    CTF_S_B2,
    CTF_S_B3,
    CTF_S_OUT
  } ctf_state_t;

  typedef enum logic [2:0] {
    CTF_OPA_ANG,
    CTF_OPA_LP,
    CTF_OPA_HP,
    CTF_OPA_RATE,
    CTF_OPA_SUM
  } ctf_opa_t;

  typedef enum logic [2:0] {
    CTF_OPB_LG,
    CTF_OPB_WL,
    CTF_OPB_HG,
    CTF_OPB_BG,
    CTF_OPB_WB,
    CTF_OPB_TICKS
  } ctf_opb_t;

  typedef struct packed {
    ctf_opa_t opa;
    ctf_opb_t opb;
    logic     hi;
    logic     acc_en;
    logic     load;
    logic     lp_load;
    logic     sum_load;
    logic     hp_load;
    logic     out_load;
  } ctf_mac_ctrl_t;

  // atan(2^-i) in degrees, Q6.24
  function automatic logic [CTF_ATAN_W-1:0] ctf_atan(input logic [4:0] idx);
    logic [CTF_ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 30'd754974720;
      5'd1:    v = 30'd445687602;
      5'd2:    v = 30'd235489088;
      5'd3:    v = 30'd119537938;
      5'd4:    v = 30'd60000934;
      5'd5:    v = 30'd30029717;
      5'd6:    v = 30'd15018523;
      5'd7:    v = 30'd7509720;
      5'd8:    v = 30'd3754917;
      5'd9:    v = 30'd1877466;
      5'd10:   v = 30'd938734;
      5'd11:   v = 30'd469367;
      5'd12:   v = 30'd234684;
      5'd13:   v = 30'd117342;
      5'd14:   v = 30'd58671;
      5'd15:   v = 30'd29335;
      5'd16:   v = 30'd14668;
      5'd17:   v = 30'd7334;
      5'd18:   v = 30'd3667;
      5'd19:   v = 30'd1833;
      5'd20:   v = 30'd917;
      5'd21:   v = 30'd458;
      5'd22:   v = 30'd229;
      5'd23:   v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ctf_cordic.sv -----
// iterative vectoring cordic giving atan2 of the accelerometer pair in degrees
module ctf_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [15:0]                  vec_x,
  input  logic signed [15:0]                  vec_y,
  output logic                                done,
  output logic signed [ctf_pkg::CTF_ANG_W-1:0] angle
);

  localparam int CW     = ctf_pkg::CTF_CW;
  localparam int RND_SH = ctf_pkg::CTF_TAB_FRAC - ctf_pkg::CTF_F;
  localparam logic signed [CW-1:0] ANG180   = CW'(180) <<< ctf_pkg::CTF_TAB_FRAC;
  localparam logic signed [CW-1:0] RND_HALF = CW'(2 ** (RND_SH - 1));

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [ctf_pkg::CTF_ITER_W-1:0]      iter_r, iter_nxt;
  logic signed [CW-1:0]                cx_r, cx_nxt;
  logic signed [CW-1:0]                cy_r, cy_nxt;
  logic signed [CW-1:0]                ang_r, ang_nxt;
  logic                                zero_r, zero_nxt;
  logic signed [CW-1:0]                dx, dy, step_ang, cx0, cy0, rnd;

  assign dx       = cy_r >>> iter_r;
  assign dy       = cx_r >>> iter_r;
  assign step_ang = $signed(CW'(ctf_pkg::ctf_atan(5'(iter_r))));
  assign cx0      = CW'(vec_x) <<< 16;
  assign cy0      = CW'(vec_y) <<< 16;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    ang_nxt  = ang_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      zero_nxt = (vec_x == 16'sd0) && (vec_y == 16'sd0);
      // left half plane: turn by a half revolution first
      if (vec_x[15]) begin
        cx_nxt  = -cx0;
        cy_nxt  = -cy0;
        ang_nxt = vec_y[15] ? -ANG180 : ANG180;
      end else begin
        cx_nxt  = cx0;
        cy_nxt  = cy0;
        ang_nxt = '0;
      end
    end else if (busy_r) begin
      if (!cy_r[CW-1]) begin
        cx_nxt  = cx_r + dx;
        cy_nxt  = cy_r - dy;
        ang_nxt = ang_r + step_ang;
      end else begin
        cx_nxt  = cx_r - dx;
        cy_nxt  = cy_r + dy;
        ang_nxt = ang_r - step_ang;
      end
      if (iter_r == ctf_pkg::CTF_ITER_W'(ctf_pkg::CTF_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        iter_nxt = iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    ang_r  <= ang_nxt;
    zero_r <= zero_nxt;
  end

  assign rnd   = (ang_r + RND_HALF) >>> RND_SH;
  assign done  = done_r;
  assign angle = zero_r ? '0 : ctf_pkg::CTF_ANG_W'(rnd);

endmodule

// ----- sv/complementary_tilt_filter.sv -----
// top level of the complementary tilt filter: sequencer, shared multiplier and state
// Each request passes through the cordic and then the sequencer before the next request can
// be accepted, provided the previous result has been taken: the cordic turns one add and
// shift datapath through 16 iterations, then come 13 sequencer steps, in which a single 43 by 13 bit
// multiply-accumulate unit forms the low-pass update, the gyro increment, the high-pass
// update and the output blend, each gain product split in a 13-bit high and 12-bit low part.
// in_ready is high only while the sequencer is idle. The result sits in an output
// register, so the next request is taken while a result still waits on out_ready.
// Gain registers are written through cfg_index and cfg_data and always accept;
// an index beyond the blend gain is ignored.
module complementary_tilt_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_z,
  input  logic signed [31:0]  in_gyro_rate,
  input  logic [7:0]          in_elapsed_ticks,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_pitch_angle,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int ANG_W = ctf_pkg::CTF_ANG_W;
  localparam int ACC_W = ctf_pkg::CTF_ACC_W;
  localparam int MA_W  = ctf_pkg::CTF_MA_W;
  localparam int MB_W  = ctf_pkg::CTF_MB_W;
  localparam int MP_W  = ctf_pkg::CTF_MP_W;
  localparam int SUM_W = ctf_pkg::CTF_SUM_W;
  localparam int SCL_W = ctf_pkg::CTF_SCL_W;
  localparam int PRD_W = ctf_pkg::CTF_PROD_W;
  localparam logic signed [ACC_W-1:0] LIMIT    = ACC_W'(ctf_pkg::CTF_LIMIT);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** 22);
  localparam logic signed [SCL_W-1:0] SCL_HALF = SCL_W'(2 ** 15);
  localparam logic signed [24:0]      GAIN_ONE = 25'(2 ** 23);

  ctf_pkg::ctf_state_t    state_r, state_nxt;
  ctf_pkg::ctf_mac_ctrl_t ctrl;

  logic [23:0]              lg_r, hg_r, bg_r;
  logic signed [24:0]       wl_r, wb_r;
  logic signed [31:0]       rate_r;
  logic [7:0]               ticks_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [ANG_W-1:0]  lp_r, hp_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [31:0]       out_r;

  logic                     accept;
  logic                     cordic_done;
  logic signed [ANG_W-1:0]  acc_angle;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [24:0]       gain_sel;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]  term, acc_rnd;
  logic signed [PRD_W-1:0]  inc_prod;
  logic signed [SCL_W-1:0]  inc_wide;

  function automatic logic signed [ANG_W-1:0] sat_angle(input logic signed [ACC_W-1:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > LIMIT) begin
      r = ANG_W'(LIMIT);
    end else if (v < -LIMIT) begin
      r = ANG_W'(-LIMIT);
    end else begin
      r = ANG_W'(v);
    end
    return r;
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ctf_pkg::CTF_S_IDLE);
  assign cfg_ready = 1'b1;

  ctf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .vec_x (in_accel_z),
    .vec_y (in_accel_x),
    .done  (cordic_done),
    .angle (acc_angle)
  );

  // gain registers, the complements of the low-pass and blend gains kept beside them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= ctf_pkg::CTF_LG_RESET;
      hg_r <= ctf_pkg::CTF_HG_RESET;
      bg_r <= ctf_pkg::CTF_BG_RESET;
      wl_r <= GAIN_ONE - $signed({1'b0, ctf_pkg::CTF_LG_RESET});
      wb_r <= GAIN_ONE - $signed({1'b0, ctf_pkg::CTF_BG_RESET});
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ctf_pkg::CTF_REG_LOWPASS: begin
          lg_r <= cfg_data;
          wl_r <= GAIN_ONE - $signed({1'b0, cfg_data});
        end
        ctf_pkg::CTF_REG_HIGHPASS: begin
          hg_r <= cfg_data;
        end
        ctf_pkg::CTF_REG_BLEND: begin
          bg_r <= cfg_data;
          wb_r <= GAIN_ONE - $signed({1'b0, cfg_data});
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctf_pkg::CTF_S_IDLE:   if (accept) state_nxt = ctf_pkg::CTF_S_CORDIC;
      ctf_pkg::CTF_S_CORDIC: if (cordic_done) state_nxt = ctf_pkg::CTF_S_LP0;
      ctf_pkg::CTF_S_LP0:    state_nxt = ctf_pkg::CTF_S_LP1;
      ctf_pkg::CTF_S_LP1:    state_nxt = ctf_pkg::CTF_S_LP2;
      ctf_pkg::CTF_S_LP2:    state_nxt = ctf_pkg::CTF_S_LP3;
      ctf_pkg::CTF_S_LP3:    state_nxt = ctf_pkg::CTF_S_LPF;
      ctf_pkg::CTF_S_LPF:    state_nxt = ctf_pkg::CTF_S_SUM;
      ctf_pkg::CTF_S_SUM:    state_nxt = ctf_pkg::CTF_S_H0;
      ctf_pkg::CTF_S_H0:     state_nxt = ctf_pkg::CTF_S_H1;
      ctf_pkg::CTF_S_H1:     state_nxt = ctf_pkg::CTF_S_HPF;
      ctf_pkg::CTF_S_HPF:    state_nxt = ctf_pkg::CTF_S_B1;
      ctf_pkg::CTF_S_B1:     state_nxt = ctf_pkg::CTF_S_B2;
      ctf_pkg::CTF_S_B2:     state_nxt = ctf_pkg::CTF_S_B3;
      ctf_pkg::CTF_S_B3:     state_nxt = ctf_pkg::CTF_S_OUT;
      ctf_pkg::CTF_S_OUT:    if (ctrl.out_load) state_nxt = ctf_pkg::CTF_S_IDLE;
      default:               state_nxt = ctf_pkg::CTF_S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl     = '0;
    ctrl.opa = ctf_pkg::CTF_OPA_ANG;
    ctrl.opb = ctf_pkg::CTF_OPB_LG;
    unique case (state_r)
      ctf_pkg::CTF_S_LP0: begin
        ctrl.opa = ctf_pkg::CTF_OPA_ANG; ctrl.opb = ctf_pkg::CTF_OPB_LG;
        ctrl.hi = 1'b1; ctrl.acc_en = 1'b1; ctrl.load = 1'b1;
      end
      ctf_pkg::CTF_S_LP1: begin
        ctrl.opa = ctf_pkg::CTF_OPA_ANG; ctrl.opb = ctf_pkg::CTF_OPB_LG;
        ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_LP2: begin
        ctrl.opa = ctf_pkg::CTF_OPA_LP; ctrl.opb = ctf_pkg::CTF_OPB_WL;
        ctrl.hi = 1'b1; ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_LP3: begin
        ctrl.opa = ctf_pkg::CTF_OPA_LP; ctrl.opb = ctf_pkg::CTF_OPB_WL;
        ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_LPF: begin
        ctrl.lp_load = 1'b1;
        ctrl.opa = ctf_pkg::CTF_OPA_RATE; ctrl.opb = ctf_pkg::CTF_OPB_TICKS;
        ctrl.acc_en = 1'b1; ctrl.load = 1'b1;
      end
      ctf_pkg::CTF_S_SUM: begin
        ctrl.sum_load = 1'b1;
      end
      ctf_pkg::CTF_S_H0: begin
        ctrl.opa = ctf_pkg::CTF_OPA_SUM; ctrl.opb = ctf_pkg::CTF_OPB_HG;
        ctrl.hi = 1'b1; ctrl.acc_en = 1'b1; ctrl.load = 1'b1;
      end
      ctf_pkg::CTF_S_H1: begin
        ctrl.opa = ctf_pkg::CTF_OPA_SUM; ctrl.opb = ctf_pkg::CTF_OPB_HG;
        ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_HPF: begin
        ctrl.hp_load = 1'b1;
        ctrl.opa = ctf_pkg::CTF_OPA_LP; ctrl.opb = ctf_pkg::CTF_OPB_BG;
        ctrl.hi = 1'b1; ctrl.acc_en = 1'b1; ctrl.load = 1'b1;
      end
      ctf_pkg::CTF_S_B1: begin
        ctrl.opa = ctf_pkg::CTF_OPA_LP; ctrl.opb = ctf_pkg::CTF_OPB_BG;
        ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_B2: begin
        ctrl.opa = ctf_pkg::CTF_OPA_HP; ctrl.opb = ctf_pkg::CTF_OPB_WB;
        ctrl.hi = 1'b1; ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_B3: begin
        ctrl.opa = ctf_pkg::CTF_OPA_HP; ctrl.opb = ctf_pkg::CTF_OPB_WB;
        ctrl.acc_en = 1'b1;
      end
      ctf_pkg::CTF_S_OUT: begin
        ctrl.out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    case (ctrl.opa)
      ctf_pkg::CTF_OPA_ANG:  mul_a = MA_W'(acc_angle);
      ctf_pkg::CTF_OPA_LP:   mul_a = MA_W'(lp_r);
      ctf_pkg::CTF_OPA_HP:   mul_a = MA_W'(hp_r);
      ctf_pkg::CTF_OPA_RATE: mul_a = MA_W'(rate_r);
      ctf_pkg::CTF_OPA_SUM:  mul_a = MA_W'(sum_r);
      default:               mul_a = '0;
    endcase
    case (ctrl.opb)
      ctf_pkg::CTF_OPB_LG:    gain_sel = $signed({1'b0, lg_r});
      ctf_pkg::CTF_OPB_WL:    gain_sel = wl_r;
      ctf_pkg::CTF_OPB_HG:    gain_sel = $signed({1'b0, hg_r});
      ctf_pkg::CTF_OPB_BG:    gain_sel = $signed({1'b0, bg_r});
      ctf_pkg::CTF_OPB_WB:    gain_sel = wb_r;
      ctf_pkg::CTF_OPB_TICKS: gain_sel = $signed(25'(ticks_r));
      default:                gain_sel = '0;
    endcase
    mul_b = ctrl.hi ? gain_sel[24:12] : $signed({1'b0, gain_sel[11:0]});
  end

  assign mul_p    = MP_W'(mul_a) * MP_W'(mul_b);
  assign term     = ctrl.hi ? (ACC_W'(mul_p) <<< 12) : ACC_W'(mul_p);
  assign acc_rnd  = (acc_r + ACC_HALF) >>> 23;
  assign inc_prod = acc_r[PRD_W-1:0];
  assign inc_wide = ((SCL_W'(inc_prod) <<< ctf_pkg::CTF_F) + SCL_W'(SCL_HALF)) >>> 16;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctf_pkg::CTF_S_IDLE;
      out_valid_r <= 1'b0;
      lp_r        <= '0;
      hp_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ctrl.lp_load) lp_r <= sat_angle(acc_rnd);
      if (ctrl.hp_load) hp_r <= sat_angle(acc_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r  <= in_gyro_rate;
      ticks_r <= in_elapsed_ticks;
    end
    if (ctrl.acc_en) begin
      acc_r <= ctrl.load ? term : acc_r + term;
    end
    if (ctrl.sum_load) begin
      sum_r <= SUM_W'(inc_wide) + SUM_W'(hp_r);
    end
    if (ctrl.out_load) begin
      out_r <= 32'(acc_rnd);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pitch_angle = out_r;

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_done |-> (state_r == ctf_pkg::CTF_S_CORDIC))
    else $error("cordic finished outside its wait state");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ctf_pkg::CTF_S_CORDIC))
    else $error("accepted request did not start the cordic");

  a_lp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ACC_W'(lp_r) <= LIMIT) && (ACC_W'(lp_r) >= -LIMIT))
    else $error("low-pass state beyond angle limit");

  a_hp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ACC_W'(hp_r) <= LIMIT) && (ACC_W'(hp_r) >= -LIMIT))
    else $error("high-pass state beyond angle limit");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule

// ----- verif/complementary_tilt_filter_tb.sv -----
// self-checking testbench of the complementary tilt filter with its own bit-exact predictor
`timescale 1ns / 1ps

module testbench;

  localparam longint GAIN_ONE     = 64'sd8388608;
  localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int PHASES         = 6;
  localparam int RANDOM_PER_PHASE = 310;
  localparam int STALL_CYCLES   = 300;
  localparam int DRAIN_CYCLES   = 64;

  localparam longint ATAN_DEG_Q24 [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] az;
    logic signed [31:0] rate;
    logic [7:0]         ticks;
  } tilt_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_z = '0;
  logic signed [31:0] in_gyro_rate = '0;
  logic [7:0]         in_elapsed_ticks = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_pitch_angle;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  tilt_sample_t       sample_queue[$];
  logic signed [31:0] pitch_expected[$];
  int samples_queued = 0;
  int pitch_checked  = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int phase_idx      = -1;
  logic stall_out    = 1'b0;

  logic               drv_fire;
  tilt_sample_t       drv_item;
  logic signed [31:0] mon_want;

  longint      lp_angle = 0;
  longint      hp_angle = 0;
  logic [23:0] lp_gain = ctf_pkg::CTF_LG_RESET;
  logic [23:0] hp_gain = ctf_pkg::CTF_HG_RESET;
  logic [23:0] bl_gain = ctf_pkg::CTF_BG_RESET;

  complementary_tilt_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_accel_x       (in_accel_x),
    .in_accel_z       (in_accel_z),
    .in_gyro_rate     (in_gyro_rate),
    .in_elapsed_ticks (in_elapsed_ticks),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pitch_angle  (out_pitch_angle),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_angle(longint v);
    if (v > longint'(ctf_pkg::CTF_LIMIT)) return longint'(ctf_pkg::CTF_LIMIT);
    if (v < -longint'(ctf_pkg::CTF_LIMIT)) return -longint'(ctf_pkg::CTF_LIMIT);
    return v;
  endfunction

  function automatic longint accel_tilt(longint y, longint x);
    longint cx;
    longint cy;
    longint ang;
    longint dx;
    longint dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    cx = x * 65536;
    cy = y * 65536;
    // negative z: turn the vector half a revolution
    if (cx < 0) begin
      ang = (y >= 0) ? (longint'(180) <<< ctf_pkg::CTF_TAB_FRAC)
                     : -(longint'(180) <<< ctf_pkg::CTF_TAB_FRAC);
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < ctf_pkg::CTF_STEPS && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        ang = ang + ATAN_DEG_Q24[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        ang = ang - ATAN_DEG_Q24[i];
      end
    end
    return round_shift(ang, ctf_pkg::CTF_TAB_FRAC - ctf_pkg::CTF_F);
  endfunction

  function automatic logic signed [31:0] predict_pitch(tilt_sample_t s);
    longint ax;
    longint az;
    longint rate;
    longint ticks;
    longint acc;
    longint lg;
    longint bg;
    longint inc;
    longint pitch;
    logic signed [95:0] wide;
    ax = s.ax;
    az = s.az;
    rate = s.rate;
    ticks = longint'({56'd0, s.ticks});
    lg = longint'({40'd0, lp_gain});
    bg = longint'({40'd0, bl_gain});
    acc = accel_tilt(ax, az);
    lp_angle = clamp_angle(round_shift(acc * lg + lp_angle * (GAIN_ONE - lg), 23));
    inc = round_shift((rate * ticks) <<< ctf_pkg::CTF_F, 16);
    wide = 96'(signed'(hp_angle + inc));
    wide = wide * $signed({72'd0, hp_gain});
    wide = (wide + 96'sd4194304) >>> 23;
    hp_angle = clamp_angle(longint'(wide));
    pitch = round_shift(lp_angle * bg + hp_angle * (GAIN_ONE - bg), 23);
    return pitch[31:0];
  endfunction

  function automatic tilt_sample_t random_sample();
    tilt_sample_t s;
    int unsigned mode;
    mode = $urandom_range(9);
    s.ax = 16'($urandom);
    s.az = 16'($urandom);
    s.rate = $urandom;
    s.ticks = 8'($urandom);
    if (mode == 0) begin
      s.ax = '0;
      s.az = '0;
    end else if (mode >= 3) begin
      // plausible motion: moderate tilt, small rate, short interval
      s.ax = 16'($urandom_range(0, 32000)) - 16'd16000;
      s.az = 16'($urandom_range(0, 40000)) - 16'd8000;
      s.rate = 32'($urandom_range(0, 1048576)) - 32'd524288;
      s.ticks = 8'($urandom_range(1, 20));
    end
    return s;
  endfunction

  task automatic add_sample(input logic [15:0] ax, input logic [15:0] az,
                            input logic [31:0] rate, input logic [7:0] ticks);
    tilt_sample_t s;
    s.ax = ax;
    s.az = az;
    s.rate = rate;
    s.ticks = ticks;
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic program_gain(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ctf_pkg::CTF_REG_LOWPASS:  lp_gain = val;
      ctf_pkg::CTF_REG_HIGHPASS: hp_gain = val;
      ctf_pkg::CTF_REG_BLEND:    bl_gain = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_directed();
    add_sample(16'd0, 16'd0, 32'd0, 8'd0);
    add_sample(16'sd32767, 16'd0, 32'd65536, 8'd1);
    add_sample(-16'sd32768, 16'd0, -32'sd65536, 8'd1);
    add_sample(16'd0, 16'sd32767, 32'd0, 8'd3);
    add_sample(16'd0, -16'sd32768, 32'd0, 8'd3);
    add_sample(-16'sd1, -16'sd32768, 32'd0, 8'd3);
    add_sample(16'sd32767, -16'sd32768, 32'd0, 8'd1);
    add_sample(-16'sd32768, -16'sd32768, 32'd0, 8'd1);
    add_sample(-16'sd32768, 16'sd32767, 32'd0, 8'd1);
    add_sample(16'sd32767, 16'sd32767, 32'd0, 8'd1);
    add_sample(16'sd1, -16'sd1, 32'd0, 8'd1);
    add_sample(-16'sd1, -16'sd1, 32'd0, 8'd1);
    add_sample(16'sd1, 16'sd1, 32'd0, 8'd1);
    add_sample(16'sd100, 16'sd200, 32'h7FFFFFFF, 8'd255);
    add_sample(16'sd100, 16'sd200, 32'h7FFFFFFF, 8'd255);
    add_sample(-16'sd100, 16'sd200, 32'h80000000, 8'd255);
    add_sample(-16'sd100, 16'sd200, 32'h80000000, 8'd255);
    add_sample(-16'sd100, 16'sd200, 32'h80000000, 8'd0);
    add_sample(16'sd4000, 16'sd16000, 32'hFFFFFFFF, 8'd255);
    add_sample(16'sd4000, -16'sd16000, 32'h00010000, 8'd128);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_fire = in_valid && in_ready;
      if (drv_fire) begin
        drv_item.ax = in_accel_x;
        drv_item.az = in_accel_z;
        drv_item.rate = in_gyro_rate;
        drv_item.ticks = in_elapsed_ticks;
        pitch_expected.push_back(predict_pitch(drv_item));
      end
      if (!in_valid || drv_fire) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = sample_queue.pop_front();
          in_accel_x       <= drv_item.ax;
          in_accel_z       <= drv_item.az;
          in_gyro_rate     <= drv_item.rate;
          in_elapsed_ticks <= drv_item.ticks;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pitch_expected.size() == 0) begin
        $error("pitch_angle expected none actual %0d", out_pitch_angle);
        mismatch_count++;
      end else begin
        mon_want = pitch_expected.pop_front();
        if (out_pitch_angle !== mon_want) begin
          $error("pitch_angle expected %0d actual %0d", mon_want, out_pitch_angle);
          mismatch_count++;
        end
        pitch_checked++;
      end
    end
    out_ready <= !stall_out && ($urandom_range(99) >= recv_idle_pct);
  end

  // long output hold-off while the sender keeps offering requests
  initial begin
    wait (phase_idx == 4);
    @(posedge clk);
    stall_out <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    stall_out <= 1'b0;
  end

  initial begin
    #5000000;
    $display("complementary_tilt_filter verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 37;
        recv_idle_pct = 67;
      end else if (phase < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        1: begin
          program_gain(ctf_pkg::CTF_REG_LOWPASS, GAIN_ONE[23:0]);
          program_gain(ctf_pkg::CTF_REG_HIGHPASS, GAIN_MAX);
          program_gain(ctf_pkg::CTF_REG_BLEND, 24'd0);
          program_gain(REG_UNUSED, 24'($urandom));
        end
        2: begin
          program_gain(ctf_pkg::CTF_REG_LOWPASS, 24'd0);
          program_gain(ctf_pkg::CTF_REG_HIGHPASS, 24'd0);
          program_gain(ctf_pkg::CTF_REG_BLEND, GAIN_MAX);
        end
        3: begin
          program_gain(ctf_pkg::CTF_REG_LOWPASS, 24'($urandom_range(0, 8388608)));
          program_gain(ctf_pkg::CTF_REG_HIGHPASS, 24'($urandom_range(0, 8388608)));
          program_gain(ctf_pkg::CTF_REG_BLEND, 24'($urandom_range(0, 8388608)));
        end
        4: begin
          program_gain(ctf_pkg::CTF_REG_LOWPASS, 24'd8346665);
          program_gain(ctf_pkg::CTF_REG_HIGHPASS, GAIN_ONE[23:0]);
          program_gain(ctf_pkg::CTF_REG_BLEND, 24'($urandom));
        end
        5: begin
          program_gain(ctf_pkg::CTF_REG_LOWPASS, 24'($urandom));
          program_gain(ctf_pkg::CTF_REG_HIGHPASS, 24'($urandom));
          program_gain(ctf_pkg::CTF_REG_BLEND, 24'($urandom));
          program_gain(REG_UNUSED, 24'($urandom));
        end
        default: ;
      endcase
      phase_idx = phase;
      if (phase == 0) queue_directed();
      repeat (RANDOM_PER_PHASE) begin
        sample_queue.push_back(random_sample());
        samples_queued++;
      end
      while (pitch_checked != samples_queued) @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pitch_expected.size() == 0) begin
      $display("complementary_tilt_filter verification clean");
    end else begin
      $display("complementary_tilt_filter verification failed");
    end
    $finish;
  end

endmodule
